@@ sv/assert_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ sv/hcw_pkg.sv @@
`default_nettype none

package hcw_pkg;

   // sizes
   localparam int MAX_ORDER_DEFAULT = 8;
   localparam int ORDER_W           = 4;
   localparam int STEP_W            = 8;
   localparam int GRID_W            = 8;
   localparam int POS_W             = 16;
   localparam int CSR_DATA_W        = 8;
   localparam int CSR_INDEX_W       = 1;

   // register reset values
   localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd4;
   localparam logic [STEP_W-1:0]  STEP_RESET  = 8'd16;

   // phase of a level that sits on the last of its four sub-curves
   localparam logic [1:0] PHASE_LAST = 2'd3;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CURVE_ORDER = 1'b0,
      CSR_STEP_SIZE   = 1'b1
   } csr_index_type;

   // move directions, also used as level orientations
   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_LEFT  = 2'd1,
      DIR_DOWN  = 2'd2,
      DIR_RIGHT = 2'd3
   } dir_type;

   // child orientation by parent orientation and phase
   localparam logic [1:0] CHILD_ORIENT [4][4] = '{
      '{2'd1, 2'd0, 2'd0, 2'd3},
      '{2'd0, 2'd1, 2'd1, 2'd2},
      '{2'd3, 2'd2, 2'd2, 2'd1},
      '{2'd2, 2'd3, 2'd3, 2'd0}
   };

   // connecting move by orientation and phase; the last column is never selected
   localparam logic [1:0] LINK_MOVE [4][4] = '{
      '{2'd2, 2'd3, 2'd0, 2'd0},
      '{2'd3, 2'd2, 2'd1, 2'd0},
      '{2'd0, 2'd1, 2'd2, 2'd0},
      '{2'd1, 2'd0, 2'd3, 2'd0}
   };

   // one move of the walk, before scaling
   typedef struct packed {
      logic [GRID_W-1:0] grid_x;
      logic [GRID_W-1:0] grid_y;
      dir_type           move_dir;
      logic              last_move;
   } walk_result_type;

endpackage

`default_nettype wire

@@ sv/hcw_req_if.sv @@
`default_nettype none

interface hcw_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

@@ sv/hcw_rsp_if.sv @@
`default_nettype none

interface hcw_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [hcw_pkg::POS_W-1:0] x_position;
   logic [hcw_pkg::POS_W-1:0] y_position;
   logic [1:0]                move_direction;
   logic                      last_move;

   modport source (output valid, output x_position, output y_position,
                   output move_direction, output last_move, input ready);
   modport sink (input valid, input x_position, input y_position,
                 input move_direction, input last_move, output ready);
endinterface

`default_nettype wire

@@ sv/hilbert_curve_walk_generator.sv @@
// Hilbert curve walk generator.
// Each item on the req_ channel asks for one move of the curve. With restart
// set, the walk begins again at grid point (0,0) and the first move is given;
// with restart clear, the next move is given. Each move comes out on the rsp_
// channel as the new position (grid point times step_size, 16 bits each),
// the move direction (0 up, 1 left, 2 down, 3 right) and a flag on the final
// move. After the final move, and before any restart, items give no result.
// Registers on the csr_ port: index 0 curve_order (1..MAX_ORDER, clamped),
// index 1 step_size. Write them only while the block is idle.
// Throughput: one item per cycle while rsp_ is taken (see Stall). Each result appears
// on rsp_ in the cycle after acceptance; the move comes from the per-level orientation
// and phase stack (pick of the lowest unfinished level) feeding the output register.
// Reset: curve_order 4, step_size 16, walk idle, output empty.
// Stall: when rsp_ is not taken, the output register holds its move and req_
// ready stays low until the move is taken.
`default_nettype none

module hilbert_curve_walk_generator #(
   parameter int MAX_ORDER = hcw_pkg::MAX_ORDER_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   hcw_req_if.sink                                req_if,
   hcw_rsp_if.source                              rsp_if,
   input  wire logic                              csr_write_enable,
   input  wire logic [hcw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [hcw_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   logic [hcw_pkg::ORDER_W-1:0] order_ff;
   logic [hcw_pkg::STEP_W-1:0]  step_ff;
   logic                        load_ok;
   logic                        accept;
   logic                        result_valid;
   hcw_pkg::walk_result_type    result;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= hcw_pkg::ORDER_RESET;
         step_ff  <= hcw_pkg::STEP_RESET;
      end else if (csr_write_enable) begin
         unique case (hcw_pkg::csr_index_type'(csr_index))
            hcw_pkg::CSR_CURVE_ORDER: order_ff <= csr_write_data[hcw_pkg::ORDER_W-1:0];
            hcw_pkg::CSR_STEP_SIZE:   step_ff  <= csr_write_data[hcw_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake on the request side
   assign req_if.ready = load_ok;
   assign accept       = req_if.valid & load_ok;

   hcw_walk #(
      .MAX_ORDER (MAX_ORDER)
   ) u_walk (
      .clock        (clock),
      .reset        (reset),
      .curve_order  (order_ff),
      .accept       (accept),
      .restart      (req_if.restart),
      .result_valid (result_valid),
      .result       (result)
   );

   hcw_out u_out (
      .clock     (clock),
      .reset     (reset),
      .step_size (step_ff),
      .take      (accept & result_valid),
      .result    (result),
      .load_ok   (load_ok),
      .rsp       (rsp_if)
   );

endmodule

`default_nettype wire

@@ sv/hcw_walk.sv @@
`default_nettype none
`include "assert_macros.svh"

module hcw_walk #(
   parameter int MAX_ORDER = hcw_pkg::MAX_ORDER_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [hcw_pkg::ORDER_W-1:0]  curve_order,
   input  wire logic                         accept,
   input  wire logic                         restart,
   output logic                              result_valid,
   output hcw_pkg::walk_result_type          result
);

   localparam int ORD_W = $clog2(MAX_ORDER + 1);
   localparam int CW    = (ORD_W > hcw_pkg::ORDER_W) ? ORD_W : hcw_pkg::ORDER_W;
   localparam int LVL_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

   // walk state
   logic [hcw_pkg::GRID_W-1:0] grid_x_ff, grid_y_ff;
   logic [1:0]                 orient_ff [MAX_ORDER];
   logic [1:0]                 phase_ff  [MAX_ORDER];
   logic                       active_ff;

   logic [CW-1:0]        order_ext, order_max, order_eff;
   logic [MAX_ORDER-1:0] level_en;

   logic [1:0]                 orient_a [MAX_ORDER];
   logic [1:0]                 phase_a  [MAX_ORDER];
   logic [hcw_pkg::GRID_W-1:0] grid_x_a, grid_y_a;
   logic                       active_a;

   logic [MAX_ORDER-1:0] found;
   logic [MAX_ORDER-1:0] below;
   logic [LVL_W-1:0]     sel_lvl;
   logic [1:0]           sel_orient, sel_phase, new_phase, child;
   logic                 found_any;
   hcw_pkg::dir_type     dir;

   logic [1:0]                 orient_b [MAX_ORDER];
   logic [1:0]                 phase_b  [MAX_ORDER];
   logic [hcw_pkg::GRID_W-1:0] grid_x_in, grid_y_in;
   logic                       last;
   logic                       step_ok;

   // effective order, clamped to 1..MAX_ORDER
   assign order_ext = CW'(curve_order);
   assign order_max = CW'(MAX_ORDER);

   always_comb begin
      if (order_ext == '0) begin
         order_eff = CW'(1);
      end else if (order_ext > order_max) begin
         order_eff = order_max;
      end else begin
         order_eff = order_ext;
      end
   end

   // restart: levels in use go to sub-curve 0, orientation alternates up/left downward
   assign active_a = active_ff | restart;
   assign grid_x_a = restart ? '0 : grid_x_ff;
   assign grid_y_a = restart ? '0 : grid_y_ff;

   for (genvar i = 0; i < MAX_ORDER; i++) begin : g_restart
      assign level_en[i] = CW'(i) < order_eff;
      assign phase_a[i]  = (restart && level_en[i]) ? 2'd0 : phase_ff[i];
      assign orient_a[i] = (restart && level_en[i]) ?
                           {1'b0, ~(order_eff[0] ^ 1'(i % 2))} : orient_ff[i];
      assign found[i]    = level_en[i] && (phase_a[i] != hcw_pkg::PHASE_LAST);
   end

   // lowest level with a sub-curve left
   always_comb begin
      sel_lvl    = '0;
      sel_orient = '0;
      sel_phase  = '0;
      found_any  = 1'b0;
      for (int j = MAX_ORDER - 1; j >= 0; j--) begin
         if (found[j]) begin
            sel_lvl    = LVL_W'(j);
            sel_orient = orient_a[j];
            sel_phase  = phase_a[j];
            found_any  = 1'b1;
         end
      end
   end

   // levels under the selected one
   always_comb begin
      logic run;
      run = 1'b1;
      for (int j = 0; j < MAX_ORDER; j++) begin
         below[j] = run & ~found[j];
         run      = below[j];
      end
   end

   assign dir       = hcw_pkg::dir_type'(hcw_pkg::LINK_MOVE[sel_orient][sel_phase]);
   assign new_phase = sel_phase + 2'd1;
   assign child     = hcw_pkg::CHILD_ORIENT[sel_orient][new_phase];

   // stack after the move: selected level advances, lower levels restart
   for (genvar i = 0; i < MAX_ORDER; i++) begin : g_step
      assign phase_b[i]  = below[i] ? 2'd0 :
                           ((found[i] && sel_lvl == LVL_W'(i)) ? new_phase : phase_a[i]);
      assign orient_b[i] = below[i] ?
                           (child ^ {1'b0, ~(sel_lvl[0] ^ 1'(i % 2))}) : orient_a[i];
   end

   // final move when every level in use sits on its last sub-curve
   always_comb begin
      last = 1'b1;
      for (int j = 0; j < MAX_ORDER; j++) begin
         if (level_en[j] && phase_b[j] != hcw_pkg::PHASE_LAST) begin
            last = 1'b0;
         end
      end
   end

   // unit move on the grid
   always_comb begin
      grid_x_in = grid_x_a;
      grid_y_in = grid_y_a;
      case (dir)
         hcw_pkg::DIR_UP:    grid_y_in = grid_y_a - 1'b1;
         hcw_pkg::DIR_LEFT:  grid_x_in = grid_x_a - 1'b1;
         hcw_pkg::DIR_DOWN:  grid_y_in = grid_y_a + 1'b1;
         default:            grid_x_in = grid_x_a + 1'b1;
      endcase
   end

   assign step_ok      = active_a & found_any;
   assign result_valid = step_ok;

   always_comb begin
      result.grid_x    = grid_x_in;
      result.grid_y    = grid_y_in;
      result.move_dir  = dir;
      result.last_move = last;
   end

   // state update on every accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_x_ff <= '0;
         grid_y_ff <= '0;
         active_ff <= 1'b0;
         for (int j = 0; j < MAX_ORDER; j++) begin
            orient_ff[j] <= '0;
            phase_ff[j]  <= '0;
         end
      end else if (accept) begin
         grid_x_ff <= step_ok ? grid_x_in : grid_x_a;
         grid_y_ff <= step_ok ? grid_y_in : grid_y_a;
         active_ff <= step_ok & ~last;
         for (int j = 0; j < MAX_ORDER; j++) begin
            orient_ff[j] <= step_ok ? orient_b[j] : orient_a[j];
            phase_ff[j]  <= step_ok ? phase_b[j]  : phase_a[j];
         end
      end
   end

   `ASSERT_IMPLY(restart_gives_move, clock, reset, accept && restart, result_valid, "restart gave no move")
   `ASSERT_NEXT(last_ends_walk, clock, reset, accept && result_valid && result.last_move, !active_ff, "walk still active after final move")
   `ASSERT_NEXT(idle_holds, clock, reset, !active_ff && !(accept && restart), !active_ff, "walk woke without restart")

endmodule

`default_nettype wire

@@ sv/hcw_out.sv @@
`default_nettype none
`include "assert_macros.svh"

module hcw_out (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [hcw_pkg::STEP_W-1:0]  step_size,
   input  wire logic                        take,
   input  wire hcw_pkg::walk_result_type    result,
   output logic                             load_ok,
   hcw_rsp_if.source                        rsp
);

   logic                      rsp_valid_ff;
   logic [hcw_pkg::POS_W-1:0] x_pos_ff, y_pos_ff;
   logic [1:0]                dir_ff;
   logic                      last_ff;
   logic [hcw_pkg::POS_W-1:0] x_pos_in, y_pos_in;

   // scale grid point by the step size
   assign x_pos_in = hcw_pkg::POS_W'(result.grid_x) * hcw_pkg::POS_W'(step_size);
   assign y_pos_in = hcw_pkg::POS_W'(result.grid_y) * hcw_pkg::POS_W'(step_size);

   // output register frees when empty or taken this cycle
   assign load_ok = ~rsp_valid_ff | rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_ok) begin
         rsp_valid_ff <= take;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load_ok && take) begin
         x_pos_ff <= x_pos_in;
         y_pos_ff <= y_pos_in;
         dir_ff   <= result.move_dir;
         last_ff  <= result.last_move;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.x_position     = x_pos_ff;
   assign rsp.y_position     = y_pos_ff;
   assign rsp.move_direction = dir_ff;
   assign rsp.last_move      = last_ff;

   `ASSERT_NEXT(take_shows_item, clock, reset, take && load_ok, rsp_valid_ff, "taken move not presented")

endmodule

`default_nettype wire
